[hw/rtl/particle_bounce_cursor_step_defines.svh]
// assertion helpers for the rtl
`ifndef PARTICLE_BOUNCE_CURSOR_STEP_DEFINES_SVH
`define PARTICLE_BOUNCE_CURSOR_STEP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBCS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pbcs check failed");

// next-cycle implication, checked outside reset
`define PBCS_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pbcs check failed");

`endif

[hw/rtl/pbcs_pkg.sv]
`default_nettype none
package pbcs_pkg;

  localparam int POS_W   = 20;
  localparam int VEL_W   = 11;
  localparam int CUR_W   = 11;
  localparam int LIM_W   = 19;
  localparam int STEP_W  = 16;
  localparam int DIFF_W  = 21;
  localparam int SQ_W    = 42;
  localparam int ROOT_W  = 21;
  localparam int NUM_W   = 36;
  localparam int QUO_W   = 16;
  localparam int IDX_W   = 2;

  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUO_W;

  localparam logic [IDX_W-1:0] REG_LOWER = 2'd0;
  localparam logic [IDX_W-1:0] REG_UPPER = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP  = 2'd2;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_ATTRACT = 2'd1;
  localparam logic [1:0] MODE_REPEL   = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [1:0]              mode;
    logic                    sx;
    logic                    sy;
  } side_t;

endpackage
`default_nettype wire

[hw/rtl/particle_bounce_cursor_step.sv]
// particle_bounce_cursor_step: one tick of one particle, bounce plus cursor pull or push
//
// input side: an item transfers on a rising edge with start high and busy low.
// busy stays low: the pipeline takes a new particle every cycle.
// result side: done is high for exactly one cycle with new_pos_x/y, new_vel_x/y
// and zero_distance; the result transfers at the end of that cycle. the receiver
// cannot stall, and none is needed since the pipeline never backs up.
// config side: cfg_valid/cfg_ready with cfg_index (0 lower_limit, 1 upper_limit,
// 2 step_length, 3 ignored) and cfg_data; cfg_ready is always high. write only
// while no particle is in flight.
// throughput: one particle per cycle.
// the depth is set by the square-root pipe (21 stages, one root bit each) and
// the divider pipe (16 stages, one quotient bit each) plus five front stages
// (bounce, advance, cursor delta, squares and products, sum) and the output register.
// reset: rst is synchronous; it clears all valid bits and loads the default
// limits 5.0 / 495.0 and step 5.0. no clearing pass is needed.
`default_nettype none
module particle_bounce_cursor_step (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [pbcs_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [pbcs_pkg::POS_W-1:0]  pos_y,
  input  wire logic signed [pbcs_pkg::VEL_W-1:0]  vel_x,
  input  wire logic signed [pbcs_pkg::VEL_W-1:0]  vel_y,
  input  wire logic        [pbcs_pkg::CUR_W-1:0]  cursor_x,
  input  wire logic        [pbcs_pkg::CUR_W-1:0]  cursor_y,
  input  wire logic        [1:0]                  cursor_mode,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [pbcs_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic        [pbcs_pkg::LIM_W-1:0]  cfg_data,
  output logic                                    done,
  output logic signed      [pbcs_pkg::POS_W-1:0]  new_pos_x,
  output logic signed      [pbcs_pkg::POS_W-1:0]  new_pos_y,
  output logic signed      [pbcs_pkg::VEL_W-1:0]  new_vel_x,
  output logic signed      [pbcs_pkg::VEL_W-1:0]  new_vel_y,
  output logic                                    zero_distance
);
  import pbcs_pkg::*;
  `include "particle_bounce_cursor_step_defines.svh"

  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam int FRONT = 5;
  localparam int LAT   = FRONT + SQRT_STAGES + DIV_STAGES + 1;

  // velocity reverses when the signed position is outside the unsigned limits
  function automatic logic signed [VEL_W-1:0] bounce(
    input logic signed [POS_W-1:0] p,
    input logic signed [VEL_W-1:0] v,
    input logic [LIM_W-1:0]        lo,
    input logic [LIM_W-1:0]        hi
  );
    logic signed [POS_W:0] pe;
    logic signed [POS_W:0] loe;
    logic signed [POS_W:0] hie;
    pe  = {p[POS_W-1], p};
    loe = signed'({{(POS_W+1-LIM_W){1'b0}}, lo});
    hie = signed'({{(POS_W+1-LIM_W){1'b0}}, hi});
    if (pe > hie || pe < loe) begin
      return (v == VEL_MIN) ? VEL_MAX : -v;
    end
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    if (v > (POS_W + 2)'(POS_MAX)) begin
      return POS_MAX;
    end
    if (v < (POS_W + 2)'(POS_MIN)) begin
      return POS_MIN;
    end
    return v[POS_W-1:0];
  endfunction

  // configuration registers
  logic [LIM_W-1:0]  lower_limit;
  logic [LIM_W-1:0]  upper_limit;
  logic [STEP_W-1:0] step_length;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit <= LIM_W'(1280);
      upper_limit <= LIM_W'(126720);
      step_length <= STEP_W'(1280);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOWER: lower_limit <= cfg_data;
        REG_UPPER: upper_limit <= cfg_data;
        REG_STEP:  step_length <= cfg_data[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  // valid bits travel alongside the data, one per register stage
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end
  assign done = vld[LAT-1];

  // stage 1: bounce test on the incoming position
  logic signed [POS_W-1:0] s1_px, s1_py;
  logic signed [VEL_W-1:0] s1_vx, s1_vy;
  logic [CUR_W-1:0]        s1_cx, s1_cy;
  logic [1:0]              s1_mode;
  always_ff @(posedge clk) begin
    s1_px   <= pos_x;
    s1_py   <= pos_y;
    s1_vx   <= bounce(pos_x, vel_x, lower_limit, upper_limit);
    s1_vy   <= bounce(pos_y, vel_y, lower_limit, upper_limit);
    s1_cx   <= cursor_x;
    s1_cy   <= cursor_y;
    s1_mode <= cursor_mode;
  end

  // stage 2: advance and saturate
  logic signed [POS_W-1:0] s2_px, s2_py;
  logic signed [VEL_W-1:0] s2_vx, s2_vy;
  logic [CUR_W-1:0]        s2_cx, s2_cy;
  logic [1:0]              s2_mode;
  always_ff @(posedge clk) begin
    s2_px   <= sat_pos((POS_W + 2)'(s1_px) + (POS_W + 2)'(s1_vx));
    s2_py   <= sat_pos((POS_W + 2)'(s1_py) + (POS_W + 2)'(s1_vy));
    s2_vx   <= s1_vx;
    s2_vy   <= s1_vy;
    s2_cx   <= s1_cx;
    s2_cy   <= s1_cy;
    s2_mode <= s1_mode;
  end

  // stage 3: offset from particle to cursor, cursor scaled to q.8
  logic signed [DIFF_W-1:0] s3_dx_next, s3_dy_next;
  logic signed [DIFF_W-1:0] s3_dx, s3_dy;
  side_t                    s3_side;
  assign s3_dx_next = signed'({2'b00, s2_cx, 8'h00}) - DIFF_W'(s2_px);
  assign s3_dy_next = signed'({2'b00, s2_cy, 8'h00}) - DIFF_W'(s2_py);
  always_ff @(posedge clk) begin
    s3_dx <= s3_dx_next;
    s3_dy <= s3_dy_next;
    s3_side.px   <= s2_px;
    s3_side.py   <= s2_py;
    s3_side.vx   <= s2_vx;
    s3_side.vy   <= s2_vy;
    s3_side.mode <= s2_mode;
    s3_side.sx   <= s3_dx_next[DIFF_W-1];
    s3_side.sy   <= s3_dy_next[DIFF_W-1];
  end

  // stage 4: squares and step products
  logic signed [2*DIFF_W-1:0]      s4_sqx, s4_sqy;
  logic signed [STEP_W+DIFF_W:0]   s4_prx, s4_pry;
  side_t                           s4_side;
  always_ff @(posedge clk) begin
    s4_sqx  <= s3_dx * s3_dx;
    s4_sqy  <= s3_dy * s3_dy;
    s4_prx  <= signed'({1'b0, step_length}) * s3_dx;
    s4_pry  <= signed'({1'b0, step_length}) * s3_dy;
    s4_side <= s3_side;
  end

  // stage 5: squared distance and product magnitudes
  logic [SQ_W-1:0]  s5_sq;
  logic [NUM_W-1:0] s5_mx, s5_my;
  side_t            s5_side;
  logic signed [STEP_W+DIFF_W:0] abs_x, abs_y;
  always_comb begin
    abs_x = s4_prx[STEP_W+DIFF_W] ? -s4_prx : s4_prx;
    abs_y = s4_pry[STEP_W+DIFF_W] ? -s4_pry : s4_pry;
  end
  always_ff @(posedge clk) begin
    s5_sq   <= unsigned'(s4_sqx) + unsigned'(s4_sqy);
    s5_mx   <= abs_x[NUM_W-1:0];
    s5_my   <= abs_y[NUM_W-1:0];
    s5_side <= s4_side;
  end

  // square root pipe with matching delay line for the rest of the item
  logic [ROOT_W-1:0] root;
  pbcs_isqrt u_isqrt (
    .clk      (clk),
    .radicand (s5_sq),
    .root     (root)
  );

  side_t            sq_side [0:SQRT_STAGES-1];
  logic [NUM_W-1:0] sq_mx   [0:SQRT_STAGES-1];
  logic [NUM_W-1:0] sq_my   [0:SQRT_STAGES-1];
  always_ff @(posedge clk) begin
    sq_side[0] <= s5_side;
    sq_mx[0]   <= s5_mx;
    sq_my[0]   <= s5_my;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sq_side[i] <= sq_side[i-1];
      sq_mx[i]   <= sq_mx[i-1];
      sq_my[i]   <= sq_my[i-1];
    end
  end

  // dividers: step * |d| / root per axis
  logic [QUO_W-1:0] qx, qy;
  pbcs_div u_div_x (
    .clk (clk),
    .num (sq_mx[SQRT_STAGES-1]),
    .den (root),
    .quo (qx)
  );
  pbcs_div u_div_y (
    .clk (clk),
    .num (sq_my[SQRT_STAGES-1]),
    .den (root),
    .quo (qy)
  );

  side_t dv_side [0:DIV_STAGES-1];
  logic  dv_zero [0:DIV_STAGES-1];
  always_ff @(posedge clk) begin
    dv_side[0] <= sq_side[SQRT_STAGES-1];
    dv_zero[0] <= (root == '0);
    for (int i = 1; i < DIV_STAGES; i++) begin
      dv_side[i] <= dv_side[i-1];
      dv_zero[i] <= dv_zero[i-1];
    end
  end

  // final stage: apply the cursor move, truncation toward zero via sign of offset
  side_t                   fin;
  logic                    fin_zero;
  logic                    fin_move;
  logic signed [QUO_W:0]   mvx, mvy;
  logic signed [POS_W+1:0] sumx, sumy;
  always_comb begin
    fin      = dv_side[DIV_STAGES-1];
    fin_zero = dv_zero[DIV_STAGES-1];
    fin_move = (fin.mode == MODE_ATTRACT) || (fin.mode == MODE_REPEL);
    mvx = fin.sx ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
    mvy = fin.sy ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
    if (fin.mode == MODE_REPEL) begin
      sumx = (POS_W + 2)'(fin.px) - (POS_W + 2)'(mvx);
      sumy = (POS_W + 2)'(fin.py) - (POS_W + 2)'(mvy);
    end else begin
      sumx = (POS_W + 2)'(fin.px) + (POS_W + 2)'(mvx);
      sumy = (POS_W + 2)'(fin.py) + (POS_W + 2)'(mvy);
    end
  end

  logic [1:0] out_mode;
  always_ff @(posedge clk) begin
    new_vel_x <= fin.vx;
    new_vel_y <= fin.vy;
    out_mode  <= fin.mode;
    zero_distance <= fin_move && fin_zero;
    if (fin_move && !fin_zero) begin
      new_pos_x <= sat_pos(sumx);
      new_pos_y <= sat_pos(sumy);
    end else begin
      new_pos_x <= fin.px;
      new_pos_y <= fin.py;
    end
  end

  `PBCS_ASSERT_IMP(a_flag_needs_move, clk, rst, done && zero_distance, (out_mode == MODE_ATTRACT) || (out_mode == MODE_REPEL))
  `PBCS_ASSERT_IMP(a_flag_keeps_pos, clk, rst, done && zero_distance, new_pos_x == $past(fin.px) && new_pos_y == $past(fin.py))
  `PBCS_ASSERT_NXT(a_no_drop, clk, rst, vld[FRONT-1], vld[FRONT])

endmodule
`default_nettype wire

[hw/rtl/pbcs_isqrt.sv]
`default_nettype none
module pbcs_isqrt (
  input  wire logic                        clk,
  input  wire logic [pbcs_pkg::SQ_W-1:0]   radicand,
  output logic      [pbcs_pkg::ROOT_W-1:0] root
);
  import pbcs_pkg::*;

  logic [SQ_W-1:0] n_q [0:SQRT_STAGES-1];
  logic [SQ_W-1:0] r_q [0:SQRT_STAGES-1];

  // one result bit per stage, bit weight walks down by two
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_first
      assign n_in = radicand;
      assign r_in = '0;
    end else begin : g_rest
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (n_in >= trial) begin
        n_q[k] <= n_in - trial;
        r_q[k] <= (r_in >> 1) + BIT;
      end else begin
        n_q[k] <= n_in;
        r_q[k] <= r_in >> 1;
      end
    end
  end

  assign root = r_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

[hw/rtl/pbcs_div.sv]
`default_nettype none
module pbcs_div (
  input  wire logic                        clk,
  input  wire logic [pbcs_pkg::NUM_W-1:0]  num,
  input  wire logic [pbcs_pkg::ROOT_W-1:0] den,
  output logic      [pbcs_pkg::QUO_W-1:0]  quo
);
  import pbcs_pkg::*;

  // quotient is known to fit QUO_W bits, so long division starts at its top bit
  logic [NUM_W-1:0]  rem_q [0:DIV_STAGES-1];
  logic [ROOT_W-1:0] den_q [0:DIV_STAGES-1];
  logic [QUO_W-1:0]  quo_q [0:DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - k;
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [NUM_W:0]    shifted;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = (NUM_W + 1)'(den_in) << SH;

    always_ff @(posedge clk) begin
      den_q[k] <= den_in;
      if ({1'b0, rem_in} >= shifted) begin
        rem_q[k] <= rem_in - shifted[NUM_W-1:0];
        quo_q[k] <= quo_in | (QUO_W'(1) << SH);
      end else begin
        rem_q[k] <= rem_in;
        quo_q[k] <= quo_in;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule
`default_nettype wire
